### rtl/depq_pkg.sv
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and constants for the double-ended priority queue unit.
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int unsigned DefaultCapacity = 256;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned CountWidth      = 9;

  typedef enum logic [1:0] {
    ACT_INSERT     = 2'd0,
    ACT_REMOVE_MIN = 2'd1,
    ACT_REMOVE_MAX = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_TAIL_RD,
    ST_TAIL_WAIT,
    ST_MOVE,
    ST_STAT_RD,
    ST_STAT,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;    // clear removed result, latch drop flag and side
    logic ins_write;  // write word value at tail, bump count
    logic clear;      // count to zero
    logic scan_init;  // reset scan indices, address entry zero
    logic rd_scan;    // read at scan index
    logic scan_acc;   // fold read word into extremes, step index
    logic rd_tail;    // read last entry
    logic move;       // write tail word over removed slot, drop count
    logic set_drop;
    logic take;       // record removed word from extreme
    logic emit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;  // index at last held entry
  } stat_t;

endpackage

### rtl/depq_ram.sv
// ----------------------------------------------------------------------------
// depq_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module depq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/depq_ctrl.sv
// ----------------------------------------------------------------------------
// depq_ctrl
// Sequencer for insert, remove and clear, followed by a min/max scan.
// ----------------------------------------------------------------------------
module depq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       action_i,
  input  depq_pkg::stat_t  stat_i,
  output depq_pkg::ctrl_t  ctrl_o,
  output logic             busy_o
);

  depq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= depq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = (state_q != depq_pkg::ST_IDLE);
    case (state_q)
      depq_pkg::ST_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          case (depq_pkg::action_e'(action_i))
            depq_pkg::ACT_INSERT: begin
              if (stat_i.full) begin
                ctrl_o.set_drop = 1'b1;
              end else begin
                ctrl_o.ins_write = 1'b1;
              end
              state_d = depq_pkg::ST_STAT_RD;
            end
            depq_pkg::ACT_CLEAR: begin
              ctrl_o.clear = 1'b1;
              state_d = depq_pkg::ST_STAT_RD;
            end
            default: begin
              state_d = stat_i.empty ? depq_pkg::ST_STAT_RD : depq_pkg::ST_SCAN_RD;
            end
          endcase
        end
      end
      depq_pkg::ST_SCAN_RD: begin
        ctrl_o.scan_init = 1'b1;
        ctrl_o.rd_scan   = 1'b1;
        state_d = depq_pkg::ST_SCAN;
      end
      depq_pkg::ST_SCAN: begin
        ctrl_o.scan_acc = 1'b1;
        ctrl_o.rd_scan  = 1'b1;
        if (stat_i.scan_last) begin
          state_d = depq_pkg::ST_TAIL_RD;
        end
      end
      depq_pkg::ST_TAIL_RD: begin
        ctrl_o.take    = 1'b1;
        ctrl_o.rd_tail = 1'b1;
        state_d = depq_pkg::ST_TAIL_WAIT;
      end
      depq_pkg::ST_TAIL_WAIT: begin
        // keep the tail address so the word is still there for the move
        ctrl_o.rd_tail = 1'b1;
        state_d = depq_pkg::ST_MOVE;
      end
      depq_pkg::ST_MOVE: begin
        ctrl_o.move = 1'b1;
        state_d = depq_pkg::ST_STAT_RD;
      end
      depq_pkg::ST_STAT_RD: begin
        if (stat_i.empty) begin
          state_d = depq_pkg::ST_DONE;
        end else begin
          ctrl_o.scan_init = 1'b1;
          ctrl_o.rd_scan   = 1'b1;
          state_d = depq_pkg::ST_STAT;
        end
      end
      depq_pkg::ST_STAT: begin
        ctrl_o.scan_acc = 1'b1;
        ctrl_o.rd_scan  = 1'b1;
        if (stat_i.scan_last) begin
          state_d = depq_pkg::ST_DONE;
        end
      end
      depq_pkg::ST_DONE: begin
        ctrl_o.emit = 1'b1;
        state_d = depq_pkg::ST_IDLE;
      end
      default: state_d = depq_pkg::ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |=> !ctrl_o.emit) else $error("double emit");
  a_move_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.move |-> $past(ctrl_o.take, 2)) else $error("move without take");
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |=> !busy_o) else $error("busy after emit");
`endif

endmodule

### rtl/depq_dp.sv
// ----------------------------------------------------------------------------
// depq_dp
// Value store, fill count, scan index and running extremes.
// ----------------------------------------------------------------------------
module depq_dp #(
  parameter int unsigned Capacity = depq_pkg::DefaultCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  depq_pkg::ctrl_t                     ctrl_i,
  input  logic [1:0]                          action_i,
  input  logic signed [depq_pkg::ValueWidth-1:0] value_i,
  output depq_pkg::stat_t                     stat_o,
  output logic                                removed_valid_o,
  output logic signed [depq_pkg::ValueWidth-1:0] removed_value_o,
  output logic                                is_empty_o,
  output logic signed [depq_pkg::ValueWidth-1:0] max_value_o,
  output logic signed [depq_pkg::ValueWidth-1:0] min_value_o,
  output logic [depq_pkg::CountWidth-1:0]     count_o,
  output logic                                dropped_o,
  output logic                                valid_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned VW = depq_pkg::ValueWidth;

  logic [CW-1:0] cnt_q;
  logic [AW-1:0] idx_q;       // next index to read during a scan
  logic [AW-1:0] acc_idx_q;   // index of word arriving from ram
  logic [AW-1:0] min_idx_q, max_idx_q, rm_idx_q;
  logic signed [VW-1:0] min_q, max_q, val_q, rm_val_q;
  logic rm_valid_q, drop_q, is_max_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata;
  logic [CW-1:0] last;

  assign last = cnt_q - CW'(1);

  always_comb begin
    we    = 1'b0;
    addr  = idx_q;
    wdata = val_q;
    if (ctrl_i.ins_write) begin
      we = 1'b1; addr = cnt_q[AW-1:0]; wdata = value_i;
    end else if (ctrl_i.scan_init) begin
      addr = '0;
    end else if (ctrl_i.rd_tail) begin
      addr = last[AW-1:0];
    end else if (ctrl_i.move) begin
      we = 1'b1; addr = rm_idx_q; wdata = rdata;
    end
  end

  depq_ram #(.Width(VW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.full      = (cnt_q >= CW'(Capacity));
  assign stat_o.scan_last = (acc_idx_q == last[AW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.ins_write) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (ctrl_i.clear) begin
      cnt_q <= '0;
    end else if (ctrl_i.move) begin
      cnt_q <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      rm_valid_q <= 1'b0;
      rm_val_q   <= '0;
      drop_q     <= ctrl_i.set_drop;
      is_max_q   <= (action_i == depq_pkg::ACT_REMOVE_MAX);
    end
    if (ctrl_i.take) begin
      rm_valid_q <= 1'b1;
      rm_idx_q   <= is_max_q ? max_idx_q : min_idx_q;
      rm_val_q   <= is_max_q ? max_q : min_q;
    end
    if (ctrl_i.scan_init) begin
      idx_q     <= AW'(1);
      acc_idx_q <= '0;
    end else if (ctrl_i.scan_acc) begin
      idx_q     <= idx_q + AW'(1);
      acc_idx_q <= acc_idx_q + AW'(1);
      if (acc_idx_q == '0 || $signed(rdata) < min_q) begin
        min_q <= rdata; min_idx_q <= acc_idx_q;
      end
      if (acc_idx_q == '0 || $signed(rdata) > max_q) begin
        max_q <= rdata; max_idx_q <= acc_idx_q;
      end
    end
    if (ctrl_i.move) val_q <= rdata;
  end

  assign valid_o         = ctrl_i.emit;
  assign removed_valid_o = rm_valid_q;
  assign removed_value_o = rm_val_q;
  assign is_empty_o      = stat_o.empty;
  assign max_value_o     = stat_o.empty ? '0 : max_q;
  assign min_value_o     = stat_o.empty ? '0 : min_q;
  assign count_o         = depq_pkg::CountWidth'(cnt_q);
  assign dropped_o       = drop_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Capacity)) else $error("count overflow");
  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ins_write |-> !stat_o.full) else $error("insert into full store");
  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.move |-> !stat_o.empty) else $error("remove from empty store");
`endif

endmodule

### rtl/double_ended_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Multiset of signed words with insert, remove-min, remove-max and clear.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o low; its single result
// appears for one cycle with valid_o high, and the receiver cannot stall it.
// The store is one single-port RAM scanned linearly, one entry per cycle.
// An insert writes the word at the tail and then scans the held words for
// the extremes; a clear, or a remove from an empty store, goes straight to
// the result; a remove scans for the extreme, moves the last word into its
// slot and scans again. The next word can be taken in the cycle after the
// result. No clearing pass after reset.
module double_ended_priority_queue_unit #(
  parameter int unsigned Capacity = depq_pkg::DefaultCapacity
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [1:0]                             action_i,
  input  logic signed [depq_pkg::ValueWidth-1:0] value_i,
  output logic                                   valid_o,
  output logic                                   removed_valid_o,
  output logic signed [depq_pkg::ValueWidth-1:0] removed_value_o,
  output logic                                   is_empty_o,
  output logic signed [depq_pkg::ValueWidth-1:0] max_value_o,
  output logic signed [depq_pkg::ValueWidth-1:0] min_value_o,
  output logic [depq_pkg::CountWidth-1:0]        count_o,
  output logic                                   dropped_o
);

  depq_pkg::ctrl_t ctrl;
  depq_pkg::stat_t stat;

  depq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .action_i, .stat_i(stat), .ctrl_o(ctrl), .busy_o
  );

  depq_dp #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .action_i, .value_i, .stat_o(stat),
    .removed_valid_o, .removed_value_o, .is_empty_o, .max_value_o,
    .min_value_o, .count_o, .dropped_o, .valid_o
  );

endmodule
